>>> src/tspfd_pkg.sv
package tspfd_pkg;

    // Field widths
    localparam int PULSE_W = 14;
    localparam int BYTE_W  = 8;
    localparam int POS_W   = 4;
    localparam int CNT_W   = 3;

    // Stream packing
    localparam int S_TDATA_W = 16;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Frame layout
    localparam int DEF_FRAME_BYTES = 12;
    localparam logic [POS_W-1:0] CHECK_POS = POS_W'(1);
    localparam logic [POS_W-1:0] SUM_FIRST = POS_W'(2);

    // Config register map
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MIN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ZERO_MAX = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MIN  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ONE_MAX  = 2'd3;

    // Reset windows
    localparam logic [PULSE_W-1:0] RST_ZERO_MIN = PULSE_W'(5);
    localparam logic [PULSE_W-1:0] RST_ZERO_MAX = PULSE_W'(20);
    localparam logic [PULSE_W-1:0] RST_ONE_MIN  = PULSE_W'(30);
    localparam logic [PULSE_W-1:0] RST_ONE_MAX  = PULSE_W'(60);

    // Checksum offset added to the data sum
    localparam logic [BYTE_W-1:0] SUM_OFFSET = 8'hFF;

    typedef struct packed {
        logic [PULSE_W-1:0] zero_min;
        logic [PULSE_W-1:0] zero_max;
        logic [PULSE_W-1:0] one_min;
        logic [PULSE_W-1:0] one_max;
    } t_windows;

    typedef struct packed {
        logic is_valid;
        logic bit_val;
    } t_pulse_class;

endpackage

>>> src/tank_sender_pulse_frame_decoder.sv
// Pulse-width frame decoder for a tank level sender.
// Slave stream: one request per measured low pulse. tdata carries the width in
// microseconds (0 = timeout), tuser carries begin_frame, which clears the frame
// and gives no result. Master stream: one request per finished byte with its
// value and frame position, tlast on the final byte, tuser flags for an
// aborted byte and a good checksum (checksum valid with tlast only).
// Config channel: write index 0..3 = zero_min, zero_max, one_min, one_max;
// always ready; the user must write only while the stream is idle, the block
// does not enforce it. A finished byte passes through the input register,
// then the result register. Throughput: one pulse per cycle while the master
// side does not stall. A pulse that ends no byte gives no result.
// Reset: windows return to 5/20 and 30/60 us, frame state clears, both
// streams go empty. When the master side stalls, the result register holds
// and the input register fills; tready drops only once both hold an item.
module tank_sender_pulse_frame_decoder #(
    parameter int FRAME_BYTES = tspfd_pkg::DEF_FRAME_BYTES
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Pulse stream
    input  logic                             i_s_tvalid,
    output logic                             o_s_tready,
    input  logic [tspfd_pkg::S_TDATA_W-1:0]  i_s_tdata,  // [13:0] pulse_us
    input  logic                             i_s_tuser,  // [0] begin_frame
    // Byte stream
    output logic                             o_m_tvalid,
    input  logic                             i_m_tready,
    output logic [tspfd_pkg::M_TDATA_W-1:0]  o_m_tdata,  // [7:0] byte_value, [11:8] byte_index
    output logic [tspfd_pkg::M_TUSER_W-1:0]  o_m_tuser,  // [0] byte_aborted, [1] checksum_ok
    output logic                             o_m_tlast,  // last_of_frame
    // Config writes
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tspfd_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [tspfd_pkg::PULSE_W-1:0]    i_cfg_data
);
    import tspfd_pkg::*;

    t_windows           r_win;
    logic               r_in_valid;
    logic               r_in_begin;
    logic [PULSE_W-1:0] r_in_pulse;
    t_pulse_class       pulse_class;
    logic               adv;
    logic               out_valid;
    logic [BYTE_W-1:0]  byte_value;
    logic [POS_W-1:0]   byte_index;
    logic               byte_aborted;
    logic               last_of_frame;
    logic               checksum_ok;

    // Config register file
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win.zero_min <= RST_ZERO_MIN;
            r_win.zero_max <= RST_ZERO_MAX;
            r_win.one_min  <= RST_ONE_MIN;
            r_win.one_max  <= RST_ONE_MAX;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_ZERO_MIN: r_win.zero_min <= i_cfg_data;
                REG_ZERO_MAX: r_win.zero_max <= i_cfg_data;
                REG_ONE_MIN:  r_win.one_min  <= i_cfg_data;
                REG_ONE_MAX:  r_win.one_max  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Input register advances whenever the result register can take a byte
    assign adv        = r_in_valid && (!out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_tready) begin
            r_in_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_tvalid && o_s_tready) begin
            r_in_begin <= i_s_tuser;
            r_in_pulse <= i_s_tdata[PULSE_W-1:0];
        end
    end

    tspfd_classify u_classify (
        .i_pulse_us (r_in_pulse),
        .i_win      (r_win),
        .o_class    (pulse_class)
    );

    tspfd_frame #(
        .FRAME_BYTES (FRAME_BYTES)
    ) u_frame (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_begin      (r_in_begin),
        .i_class      (pulse_class),
        .i_out_taken  (i_m_tready),
        .o_valid      (out_valid),
        .o_byte_value (byte_value),
        .o_byte_index (byte_index),
        .o_aborted    (byte_aborted),
        .o_last       (last_of_frame),
        .o_ok         (checksum_ok)
    );

    // Output packing
    assign o_m_tvalid = out_valid;
    assign o_m_tdata  = {(M_TDATA_W - BYTE_W - POS_W)'(0), byte_index, byte_value};
    assign o_m_tuser  = {checksum_ok, byte_aborted};
    assign o_m_tlast  = last_of_frame;

    // Byte position stays inside the frame
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (byte_index <= POS_W'(FRAME_BYTES - 1)))
        else $error("byte index beyond frame");

    // Checksum flag only rides on the final byte
    a_ok_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && checksum_ok) |-> last_of_frame)
        else $error("checksum_ok without last_of_frame");

    // Aborted bytes carry value zero
    a_abort_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && byte_aborted) |-> (byte_value == '0))
        else $error("aborted byte with nonzero value");

endmodule

>>> src/tspfd_classify.sv
module tspfd_classify (
    input  logic [tspfd_pkg::PULSE_W-1:0] i_pulse_us,
    input  tspfd_pkg::t_windows           i_win,
    output tspfd_pkg::t_pulse_class       o_class
);
    import tspfd_pkg::*;

    logic nonzero;
    logic in_zero;
    logic in_one;

    // Window compares; a zero width is a timeout and never valid
    assign nonzero = (i_pulse_us != '0);
    assign in_zero = nonzero && (i_pulse_us >= i_win.zero_min) && (i_pulse_us <= i_win.zero_max);
    assign in_one  = nonzero && (i_pulse_us >= i_win.one_min) && (i_pulse_us <= i_win.one_max);

    // Zero window has priority on overlap
    assign o_class.is_valid = in_zero || in_one;
    assign o_class.bit_val  = !in_zero;

endmodule

>>> src/tspfd_frame.sv
module tspfd_frame #(
    parameter int FRAME_BYTES = tspfd_pkg::DEF_FRAME_BYTES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_adv,
    input  logic                          i_begin,
    input  tspfd_pkg::t_pulse_class       i_class,
    input  logic                          i_out_taken,
    output logic                          o_valid,
    output logic [tspfd_pkg::BYTE_W-1:0]  o_byte_value,
    output logic [tspfd_pkg::POS_W-1:0]   o_byte_index,
    output logic                          o_aborted,
    output logic                          o_last,
    output logic                          o_ok
);
    import tspfd_pkg::*;

    localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
    localparam logic [POS_W-1:0] SUM_LAST = POS_W'(FRAME_BYTES - 2);

    // Frame state
    logic [BYTE_W-1:0] r_bit_shift, n_bit_shift;
    logic [CNT_W-1:0]  r_bit_count, n_bit_count;
    logic [POS_W-1:0]  r_frame_pos, n_frame_pos;
    logic [BYTE_W-1:0] r_data_sum,  n_data_sum;
    logic [BYTE_W-1:0] r_check,     n_check;
    logic              r_done,      n_done;

    // Result register
    logic              r_valid;
    logic [BYTE_W-1:0] r_value;
    logic [POS_W-1:0]  r_index;
    logic              r_aborted;
    logic              r_last;
    logic              r_ok;

    logic              emit;
    logic [BYTE_W-1:0] emit_value;
    logic              emit_aborted;
    logic              emit_last;
    logic              emit_ok;
    logic [BYTE_W-1:0] shifted;

    assign shifted = {r_bit_shift[BYTE_W-2:0], i_class.bit_val};

    // Next state and result for the item in the input register
    always_comb begin
        n_bit_shift  = r_bit_shift;
        n_bit_count  = r_bit_count;
        n_frame_pos  = r_frame_pos;
        n_data_sum   = r_data_sum;
        n_check      = r_check;
        n_done       = r_done;
        emit         = 1'b0;
        emit_value   = '0;
        emit_aborted = 1'b0;
        emit_last    = 1'b0;
        emit_ok      = 1'b0;

        if (i_begin) begin
            n_bit_shift = '0;
            n_bit_count = '0;
            n_frame_pos = '0;
            n_data_sum  = '0;
            n_check     = '0;
            n_done      = 1'b0;
        end else if (!r_done) begin
            if (!i_class.is_valid) begin
                emit         = 1'b1;
                emit_aborted = 1'b1;
            end else begin
                n_bit_shift = shifted;
                n_bit_count = r_bit_count + CNT_W'(1);
                if (r_bit_count == '1) begin
                    emit       = 1'b1;
                    emit_value = shifted;
                end
            end

            // Byte close-out: checksum bookkeeping and position advance
            if (emit) begin
                emit_last = (r_frame_pos == LAST_POS);
                if (r_frame_pos == CHECK_POS) begin
                    n_check = emit_value;
                end
                if ((r_frame_pos >= SUM_FIRST) && (r_frame_pos <= SUM_LAST)) begin
                    n_data_sum = BYTE_W'(r_data_sum + emit_value);
                end
                if (emit_last) begin
                    emit_ok = (r_check == BYTE_W'(r_data_sum + SUM_OFFSET));
                    n_done  = 1'b1;
                end
                n_frame_pos = r_frame_pos + POS_W'(1);
                n_bit_shift = '0;
                n_bit_count = '0;
            end
        end
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit_shift <= '0;
            r_bit_count <= '0;
            r_frame_pos <= '0;
            r_data_sum  <= '0;
            r_check     <= '0;
            r_done      <= 1'b0;
        end else if (i_adv) begin
            r_bit_shift <= n_bit_shift;
            r_bit_count <= n_bit_count;
            r_frame_pos <= n_frame_pos;
            r_data_sum  <= n_data_sum;
            r_check     <= n_check;
            r_done      <= n_done;
        end
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_adv && emit) begin
            r_valid <= 1'b1;
        end else if (i_out_taken) begin
            r_valid <= 1'b0;
        end
    end

    // Output payload
    always_ff @(posedge i_clk) begin
        if (i_adv && emit) begin
            r_value   <= emit_value;
            r_index   <= r_frame_pos;
            r_aborted <= emit_aborted;
            r_last    <= emit_last;
            r_ok      <= emit_ok;
        end
    end

    assign o_valid      = r_valid;
    assign o_byte_value = r_value;
    assign o_byte_index = r_index;
    assign o_aborted    = r_aborted;
    assign o_last       = r_last;
    assign o_ok         = r_ok;

endmodule
